>>> sv/lamb_pkg.sv
// Shared constants and types of the look-at matrix builder.
// Used by look_at_matrix_builder_unit; depends on nothing else.
package lamb_pkg;

   localparam int unsigned CoordWidth = 32;
   localparam int unsigned WideWidth  = 50;
   localparam int unsigned UnitWidth  = 18;
   localparam int unsigned UpWidth    = 19;
   localparam int unsigned MulWidth   = 33;

   typedef logic signed [CoordWidth-1:0] coord_type;
   typedef logic signed [WideWidth-1:0]  wide_type;
   typedef logic        [WideWidth-1:0]  mag_type;
   typedef logic signed [UnitWidth-1:0]  unit_type;
   typedef logic signed [UpWidth-1:0]    up_type;

   localparam logic [1:0] CSR_UP_HINT_X = 2'd0;
   localparam logic [1:0] CSR_UP_HINT_Y = 2'd1;
   localparam logic [1:0] CSR_UP_HINT_Z = 2'd2;

   localparam logic [1:0] ROW_RIGHT   = 2'd0;
   localparam logic [1:0] ROW_UP      = 2'd1;
   localparam logic [1:0] ROW_FORWARD = 2'd2;
   localparam logic [1:0] ROW_EYE     = 2'd3;

   localparam coord_type ONE_Q16      = 32'sd65536;
   localparam mag_type   CROSS_MIN    = 50'd4295;
   localparam logic [61:0] CROSS_MIN_SQ = 62'd18447025;
   localparam mag_type   NORM_HI      = 50'd1 << 30;
   localparam mag_type   NORM_LO      = 50'd1 << 29;

endpackage

>>> sv/look_at_matrix_builder_unit.sv
// Look-at camera basis builder: one shared multiplier, a bit-serial square root
// and a restoring divider under one sequencer. Depends on lamb_pkg.
//
// channel  dir  handshake           payload
// req      in   req_tvalid/tready   tdata: eye_x,eye_y,eye_z,target_x,target_y,target_z
// rsp      out  rsp_tvalid/tready   tdata: elem_x,elem_y,elem_z; tuser: row_index; tlast
// csr      in   csr_valid/ready     csr_index, csr_data
//
// One beat in gives four beats out. The forward normalize is skipped when the eye equals
// the aim point, the right normalize is skipped, keeping the last right vector, when the
// right cross product is too short, and both run otherwise. Each normalize costs up to 29 shift steps,
// 32 square root steps and three divides; the single 33 x 33 multiplier handles
// the cross products and the squares. The input is not ready until the last result beat has
// gone. Reset is synchronous and restores the up hint (0, 1.0, 0) and the right vector (1.0, 0, 0).
module look_at_matrix_builder_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // eye_x, eye_y, eye_z, target_x, target_y, target_z
   input  logic [191:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // elem_x, elem_y, elem_z
   output logic [95:0]  rsp_tdata,
   // row_index
   output logic [1:0]   rsp_tuser,
   output logic         rsp_tlast,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_data
);

   typedef enum logic [4:0] {
      ST_IDLE, ST_MAG, ST_ZCHK, ST_SHIFT, ST_SQ_MUL, ST_SQ_ACC, ST_SQ_DONE,
      ST_SQRT, ST_DIV_INIT, ST_DIV, ST_DIV_DONE, ST_CR_MUL, ST_CR_ACC,
      ST_UP_MUL, ST_UP_ACC, ST_UP_RND, ST_OUT
   } state_type;

   state_type            state_ff;
   lamb_pkg::coord_type  hint_ff [3];
   lamb_pkg::coord_type  eye_ff  [3];
   lamb_pkg::wide_type   vec_ff  [3];
   lamb_pkg::mag_type    m_ff    [3];
   lamb_pkg::unit_type   fwd_ff  [3];
   lamb_pkg::unit_type   kept_ff [3];
   lamb_pkg::up_type     up_ff   [3];
   logic                 right_ff;
   logic                 thr_ff;
   logic [2:0]           step_ff;
   logic [4:0]           cnt_ff;
   logic [61:0]          sum_ff;
   logic [61:0]          x_ff;
   logic [63:0]          res_ff;
   logic [31:0]          len_ff;
   logic [31:0]          rem_ff;
   logic [16:0]          numlo_ff;
   logic [16:0]          quo_ff;
   logic signed [65:0]   prod_ff;
   logic [1:0]           row_ff;

   lamb_pkg::mag_type    mx;
   logic [1:0]           sel;
   lamb_pkg::mag_type    m_sel;
   lamb_pkg::wide_type   v_sel;
   logic signed [32:0]   mul_a;
   logic signed [32:0]   mul_b;
   logic [63:0]          sq_bit;
   logic [63:0]          sq_trial;
   logic [63:0]          sq_res_in;
   logic [46:0]          num_in;
   logic [32:0]          div_r2;
   logic                 div_ge;
   lamb_pkg::wide_type   prod_w;
   logic [1:0]           acc_e;

   function automatic lamb_pkg::mag_type mag_of(input lamb_pkg::wide_type v);
      lamb_pkg::mag_type r;
      r = v[49] ? lamb_pkg::mag_type'(-v) : lamb_pkg::mag_type'(v);
      return r;
   endfunction

   function automatic lamb_pkg::up_type round_up(input lamb_pkg::wide_type v);
      lamb_pkg::mag_type q;
      q = (mag_of(v) + 50'h8000) >> 16;
      return v[49] ? -lamb_pkg::up_type'(q[18:0]) : lamb_pkg::up_type'(q[18:0]);
   endfunction

   always_comb begin
      mx = m_ff[0];
      if (m_ff[1] > mx) begin
         mx = m_ff[1];
      end
      if (m_ff[2] > mx) begin
         mx = m_ff[2];
      end
      acc_e = (step_ff == 3'd0 || step_ff == 3'd1) ? 2'd0 :
              (step_ff == 3'd2 || step_ff == 3'd3) ? 2'd1 : 2'd2;
      sel   = (state_ff == ST_CR_ACC || state_ff == ST_UP_ACC) ? acc_e : step_ff[1:0];
      m_sel = (sel == 2'd0) ? m_ff[0] : (sel == 2'd1) ? m_ff[1] : m_ff[2];
      v_sel = (sel == 2'd0) ? vec_ff[0] : (sel == 2'd1) ? vec_ff[1] : vec_ff[2];
      prod_w = lamb_pkg::wide_type'(prod_ff);
   end

   always_comb begin
      mul_a = 33'sd0;
      mul_b = 33'sd0;
      case (state_ff)
         ST_SQ_MUL: begin
            mul_a = {1'b0, m_sel[31:0]};
            mul_b = {1'b0, m_sel[31:0]};
         end
         ST_CR_MUL: begin
            case (step_ff)
               3'd0: begin mul_a = 33'(hint_ff[1]); mul_b = 33'(fwd_ff[2]); end
               3'd1: begin mul_a = 33'(hint_ff[2]); mul_b = 33'(fwd_ff[1]); end
               3'd2: begin mul_a = 33'(hint_ff[2]); mul_b = 33'(fwd_ff[0]); end
               3'd3: begin mul_a = 33'(hint_ff[0]); mul_b = 33'(fwd_ff[2]); end
               3'd4: begin mul_a = 33'(hint_ff[0]); mul_b = 33'(fwd_ff[1]); end
               default: begin mul_a = 33'(hint_ff[1]); mul_b = 33'(fwd_ff[0]); end
            endcase
         end
         ST_UP_MUL: begin
            case (step_ff)
               3'd0: begin mul_a = 33'(fwd_ff[1]); mul_b = 33'(kept_ff[2]); end
               3'd1: begin mul_a = 33'(fwd_ff[2]); mul_b = 33'(kept_ff[1]); end
               3'd2: begin mul_a = 33'(fwd_ff[2]); mul_b = 33'(kept_ff[0]); end
               3'd3: begin mul_a = 33'(fwd_ff[0]); mul_b = 33'(kept_ff[2]); end
               3'd4: begin mul_a = 33'(fwd_ff[0]); mul_b = 33'(kept_ff[1]); end
               default: begin mul_a = 33'(fwd_ff[1]); mul_b = 33'(kept_ff[0]); end
            endcase
         end
         default: begin
            mul_a = 33'sd0;
            mul_b = 33'sd0;
         end
      endcase
   end

   always_comb begin
      sq_bit   = 64'd1 << {cnt_ff, 1'b0};
      sq_trial = res_ff + sq_bit;
      if ({2'd0, x_ff} >= sq_trial) begin
         sq_res_in = {1'b0, res_ff[63:1]} + sq_bit;
      end else begin
         sq_res_in = {1'b0, res_ff[63:1]};
      end
      num_in = {m_sel[29:0], 16'd0} + {16'd0, len_ff[31:1]};
      div_r2 = {rem_ff, numlo_ff[16]};
      div_ge = div_r2 >= {1'b0, len_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         hint_ff[0] <= 32'sd0;
         hint_ff[1] <= lamb_pkg::ONE_Q16;
         hint_ff[2] <= 32'sd0;
         kept_ff[0] <= 18'sd65536;
         kept_ff[1] <= 18'sd0;
         kept_ff[2] <= 18'sd0;
         right_ff   <= 1'b0;
         thr_ff     <= 1'b0;
         step_ff    <= 3'd0;
         cnt_ff     <= 5'd0;
         row_ff     <= 2'd0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               lamb_pkg::CSR_UP_HINT_X: hint_ff[0] <= csr_data;
               lamb_pkg::CSR_UP_HINT_Y: hint_ff[1] <= csr_data;
               lamb_pkg::CSR_UP_HINT_Z: hint_ff[2] <= csr_data;
               default: ;
            endcase
         end
         prod_ff <= mul_a * mul_b;
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  for (int i = 0; i < 3; i++) begin
                     eye_ff[i] <= req_tdata[32*i +: 32];
                     vec_ff[i] <= lamb_pkg::wide_type'(
                        $signed(req_tdata[32*i +: 32])) -
                        lamb_pkg::wide_type'($signed(req_tdata[32*(i+3) +: 32]));
                  end
                  right_ff <= 1'b0;
                  state_ff <= ST_MAG;
               end
            end
            ST_MAG: begin
               for (int i = 0; i < 3; i++) begin
                  m_ff[i] <= mag_of(vec_ff[i]);
               end
               state_ff <= ST_ZCHK;
            end
            ST_ZCHK: begin
               step_ff <= 3'd0;
               sum_ff  <= 62'd0;
               thr_ff  <= 1'b0;
               if (!right_ff) begin
                  if (mx == '0) begin
                     for (int i = 0; i < 3; i++) begin
                        fwd_ff[i] <= 18'sd0;
                     end
                     state_ff <= ST_CR_MUL;
                  end else begin
                     state_ff <= ST_SHIFT;
                  end
               end else if (m_ff[0] >= lamb_pkg::CROSS_MIN || m_ff[1] >= lamb_pkg::CROSS_MIN ||
                            m_ff[2] >= lamb_pkg::CROSS_MIN) begin
                  state_ff <= ST_SHIFT;
               end else begin
                  thr_ff   <= 1'b1;
                  state_ff <= ST_SQ_MUL;
               end
            end
            ST_SHIFT: begin
               step_ff <= 3'd0;
               sum_ff  <= 62'd0;
               thr_ff  <= 1'b0;
               if (mx >= lamb_pkg::NORM_HI) begin
                  for (int i = 0; i < 3; i++) begin
                     m_ff[i] <= m_ff[i] >> 1;
                  end
               end else if (mx < lamb_pkg::NORM_LO) begin
                  for (int i = 0; i < 3; i++) begin
                     m_ff[i] <= m_ff[i] << 1;
                  end
               end else begin
                  state_ff <= ST_SQ_MUL;
               end
            end
            ST_SQ_MUL: begin
               state_ff <= ST_SQ_ACC;
            end
            ST_SQ_ACC: begin
               sum_ff  <= sum_ff + prod_ff[61:0];
               step_ff <= step_ff + 3'd1;
               state_ff <= (step_ff == 3'd2) ? ST_SQ_DONE : ST_SQ_MUL;
            end
            ST_SQ_DONE: begin
               step_ff <= 3'd0;
               if (thr_ff) begin
                  state_ff <= (sum_ff >= lamb_pkg::CROSS_MIN_SQ) ? ST_SHIFT : ST_UP_MUL;
               end else begin
                  x_ff     <= sum_ff;
                  res_ff   <= 64'd0;
                  cnt_ff   <= 5'd31;
                  state_ff <= ST_SQRT;
               end
            end
            ST_SQRT: begin
               if ({2'd0, x_ff} >= sq_trial) begin
                  x_ff <= x_ff - sq_trial[61:0];
               end
               res_ff <= sq_res_in;
               if (cnt_ff == 5'd0) begin
                  len_ff   <= sq_res_in[31:0];
                  step_ff  <= 3'd0;
                  state_ff <= ST_DIV_INIT;
               end else begin
                  cnt_ff <= cnt_ff - 5'd1;
               end
            end
            ST_DIV_INIT: begin
               rem_ff   <= {2'd0, num_in[46:17]};
               numlo_ff <= num_in[16:0];
               quo_ff   <= 17'd0;
               cnt_ff   <= 5'd16;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               rem_ff   <= div_ge ? 32'(div_r2 - {1'b0, len_ff}) : div_r2[31:0];
               numlo_ff <= {numlo_ff[15:0], 1'b0};
               quo_ff   <= {quo_ff[15:0], div_ge};
               if (cnt_ff == 5'd0) begin
                  state_ff <= ST_DIV_DONE;
               end else begin
                  cnt_ff <= cnt_ff - 5'd1;
               end
            end
            ST_DIV_DONE: begin
               if (right_ff) begin
                  kept_ff[sel] <= v_sel[49] ? -lamb_pkg::unit_type'({1'b0, quo_ff})
                                            : lamb_pkg::unit_type'({1'b0, quo_ff});
               end else begin
                  fwd_ff[sel] <= v_sel[49] ? -lamb_pkg::unit_type'({1'b0, quo_ff})
                                           : lamb_pkg::unit_type'({1'b0, quo_ff});
               end
               if (step_ff == 3'd2) begin
                  step_ff  <= 3'd0;
                  state_ff <= right_ff ? ST_UP_MUL : ST_CR_MUL;
               end else begin
                  step_ff  <= step_ff + 3'd1;
                  state_ff <= ST_DIV_INIT;
               end
            end
            ST_CR_MUL: begin
               state_ff <= ST_CR_ACC;
            end
            ST_CR_ACC: begin
               vec_ff[acc_e] <= step_ff[0] ? v_sel - prod_w : prod_w;
               if (step_ff == 3'd5) begin
                  right_ff <= 1'b1;
                  state_ff <= ST_MAG;
               end else begin
                  step_ff  <= step_ff + 3'd1;
                  state_ff <= ST_CR_MUL;
               end
            end
            ST_UP_MUL: begin
               state_ff <= ST_UP_ACC;
            end
            ST_UP_ACC: begin
               vec_ff[acc_e] <= step_ff[0] ? v_sel - prod_w : prod_w;
               if (step_ff == 3'd5) begin
                  state_ff <= ST_UP_RND;
               end else begin
                  step_ff  <= step_ff + 3'd1;
                  state_ff <= ST_UP_MUL;
               end
            end
            ST_UP_RND: begin
               for (int i = 0; i < 3; i++) begin
                  up_ff[i] <= round_up(vec_ff[i]);
               end
               row_ff   <= lamb_pkg::ROW_RIGHT;
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (rsp_tready) begin
                  row_ff <= row_ff + 2'd1;
                  if (row_ff == lamb_pkg::ROW_EYE) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tuser  = row_ff;
   assign rsp_tlast  = (row_ff == lamb_pkg::ROW_EYE);

   always_comb begin
      case (row_ff)
         lamb_pkg::ROW_RIGHT: rsp_tdata = {32'(kept_ff[2]), 32'(kept_ff[1]), 32'(kept_ff[0])};
         lamb_pkg::ROW_UP:    rsp_tdata = {32'(up_ff[2]), 32'(up_ff[1]), 32'(up_ff[0])};
         lamb_pkg::ROW_FORWARD: rsp_tdata = {32'(fwd_ff[2]), 32'(fwd_ff[1]), 32'(fwd_ff[0])};
         default:             rsp_tdata = {eye_ff[2], eye_ff[1], eye_ff[0]};
      endcase
   end

   // The input side and the result side are never open at the same time.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input ready while results are pending");

   // An accepted beat starts the work, so the next cycle is busy.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input still ready after a beat was taken");

   // The divider only runs with a normalized length.
   a_len_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (len_ff[31:29] != 3'd0))
      else $error("divider length out of range");

   // The last result beat returns the block to idle.
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> req_tready)
      else $error("block not idle after the last row");

endmodule

>>> tb/tb_look_at_matrix_builder_unit.sv
// Self-checking testbench of the look-at matrix builder: predicts the four basis rows
// of every eye/aim beat and compares them with the result stream. Depends on lamb_pkg.
`timescale 1ns / 1ps
module tb_look_at_matrix_builder_unit;

   typedef struct packed {
      logic [1:0]  row;
      logic [31:0] ex;
      logic [31:0] ey;
      logic [31:0] ez;
      logic        last;
   } row_beat_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [191:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [95:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [1:0]   csr_index = '0;
   logic [31:0]  csr_data = '0;

   row_beat_type expected_rows[$];
   longint       hint[3];
   longint       kept_right[3];
   int           failures = 0;
   longint       cycle = 0;
   int           idle_pct = 22;

   look_at_matrix_builder_unit i_dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > 64'd3000000) begin
         $display("tb_look_at_matrix_builder_unit: FAIL");
         $finish;
      end
   end

   function automatic longint magnitude(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint int_sqrt(longint x);
      longint unsigned r, b, y;
      y = x;
      r = 0;
      b = 64'd1 << 62;
      while (b > y) b >>= 2;
      while (b != 0) begin
         if (y >= r + b) begin
            y -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   task automatic normalize_vec(input longint v[3], output longint o[3]);
      longint unsigned m[3], mx, len, q;
      for (int i = 0; i < 3; i++) m[i] = magnitude(v[i]);
      mx = m[0];
      if (m[1] > mx) mx = m[1];
      if (m[2] > mx) mx = m[2];
      if (mx == 0) begin
         o[0] = 0; o[1] = 0; o[2] = 0;
         return;
      end
      while (mx >= (64'd1 << 30)) begin
         for (int i = 0; i < 3; i++) m[i] >>= 1;
         mx >>= 1;
      end
      while (mx < (64'd1 << 29)) begin
         for (int i = 0; i < 3; i++) m[i] <<= 1;
         mx <<= 1;
      end
      len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
      for (int i = 0; i < 3; i++) begin
         q = ((m[i] << 16) + (len >> 1)) / len;
         o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
      end
   endtask

   function automatic longint round_to_q16(longint p);
      longint q;
      q = (magnitude(p) + 64'h8000) >>> 16;
      return p < 0 ? -q : q;
   endfunction

   task automatic predict_basis(input logic [191:0] d);
      longint eye[3], dif[3], fwd[3], cr[3], up[3];
      longint unsigned m0, m1, m2;
      row_beat_type r;
      for (int i = 0; i < 3; i++) begin
         eye[i] = longint'($signed(d[32*i +: 32]));
         dif[i] = eye[i] - longint'($signed(d[32*(i+3) +: 32]));
      end
      normalize_vec(dif, fwd);
      cr[0] = hint[1] * fwd[2] - hint[2] * fwd[1];
      cr[1] = hint[2] * fwd[0] - hint[0] * fwd[2];
      cr[2] = hint[0] * fwd[1] - hint[1] * fwd[0];
      m0 = magnitude(cr[0]);
      m1 = magnitude(cr[1]);
      m2 = magnitude(cr[2]);
      if (m0 >= 4295 || m1 >= 4295 || m2 >= 4295 ||
          m0 * m0 + m1 * m1 + m2 * m2 >= 64'd4295 * 64'd4295)
         normalize_vec(cr, kept_right);
      up[0] = round_to_q16(fwd[1] * kept_right[2] - fwd[2] * kept_right[1]);
      up[1] = round_to_q16(fwd[2] * kept_right[0] - fwd[0] * kept_right[2]);
      up[2] = round_to_q16(fwd[0] * kept_right[1] - fwd[1] * kept_right[0]);
      r = '{lamb_pkg::ROW_RIGHT, kept_right[0][31:0], kept_right[1][31:0],
            kept_right[2][31:0], 1'b0};
      expected_rows.push_back(r);
      r = '{lamb_pkg::ROW_UP, up[0][31:0], up[1][31:0], up[2][31:0], 1'b0};
      expected_rows.push_back(r);
      r = '{lamb_pkg::ROW_FORWARD, fwd[0][31:0], fwd[1][31:0], fwd[2][31:0], 1'b0};
      expected_rows.push_back(r);
      r = '{lamb_pkg::ROW_EYE, eye[0][31:0], eye[1][31:0], eye[2][31:0], 1'b1};
      expected_rows.push_back(r);
   endtask

   always @(posedge clock) begin
      row_beat_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rows.size() == 0) begin
            $error("unexpected result beat");
            failures++;
         end else begin
            e = expected_rows.pop_front();
            if (rsp_tuser !== e.row) begin
               $error("row_index expected %0d actual %0d", e.row, rsp_tuser);
               failures++;
            end
            if (rsp_tdata[31:0] !== e.ex) begin
               $error("elem_x expected %h actual %h", e.ex, rsp_tdata[31:0]);
               failures++;
            end
            if (rsp_tdata[63:32] !== e.ey) begin
               $error("elem_y expected %h actual %h", e.ey, rsp_tdata[63:32]);
               failures++;
            end
            if (rsp_tdata[95:64] !== e.ez) begin
               $error("elem_z expected %h actual %h", e.ez, rsp_tdata[95:64]);
               failures++;
            end
            if (rsp_tlast !== e.last) begin
               $error("last_row expected %0d actual %0d", e.last, rsp_tlast);
               failures++;
            end
         end
      end
      rsp_tready <= ($urandom_range(99) >= idle_pct);
   end

   task automatic send_item(input logic [191:0] d);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_basis(d);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_rows.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_hint(input logic [1:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      hint[idx] = longint'($signed(val));
   endtask

   task automatic set_hint(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
      drain_results();
      write_hint(lamb_pkg::CSR_UP_HINT_X, x);
      write_hint(lamb_pkg::CSR_UP_HINT_Y, y);
      write_hint(lamb_pkg::CSR_UP_HINT_Z, z);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(1 << 20) - (1 << 19);
         2: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom)};
         default: return 32'($urandom_range(8)) << $urandom_range(31);
      endcase
   endfunction

   function automatic logic [191:0] rand_item();
      logic [191:0] d;
      for (int i = 0; i < 6; i++) d[32*i +: 32] = rand_coord();
      if ($urandom_range(15) == 0) d[191:96] = d[95:0];
      return d;
   endfunction

   task automatic test_directed();
      logic [31:0] mn, mx;
      mn = 32'h80000000;
      mx = 32'h7fffffff;
      send_item({96'd0, 96'd0});
      send_item({32'd0, 32'd0, 32'd0, 32'sd65536, 32'd0, 32'd0});
      send_item({mn, mn, mn, mx, mx, mx});
      send_item({mx, mx, mx, mn, mn, mn});
      send_item({mn, mx, mn, mx, mn, mx});
      send_item({32'd0, 32'd0, 32'd0, 32'd0, 32'sd65536, 32'd0});
      send_item({32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0});
      send_item({32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0});
      send_item({32'h12345678, 32'h0abcdef0, 32'hfedcba98, 32'h1, 32'h2, 32'h3});
      send_item({32'd0, 32'd0, 32'd0, 32'd0, 32'hffff0000, 32'd0});
   endtask

   task automatic test_random(input int n);
      for (int i = 0; i < n; i++) begin
         idle_pct = (i >= n / 3 && i < n / 2) ? 0 : 22;
         send_item(rand_item());
      end
      idle_pct = 22;
   endtask

   task automatic test_hint_sweep();
      set_hint(32'd0, 32'd0, 32'd0);
      send_item(rand_item());
      send_item(rand_item());
      set_hint(32'h7fffffff, 32'h80000000, 32'h7fffffff);
      test_random(30);
      set_hint(32'h80000000, 32'h80000000, 32'h80000000);
      test_random(30);
      set_hint(32'd0, 32'd0, 32'sd65536);
      send_item({32'd0, 32'd0, 32'sd65536, 32'd0, 32'd0, 32'd0});
      test_random(30);
      set_hint(32'd1, 32'd0, 32'd0);
      test_random(20);
   endtask

   initial begin
      hint[0] = 0; hint[1] = 65536; hint[2] = 0;
      kept_right[0] = 65536; kept_right[1] = 0; kept_right[2] = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(200);
      test_hint_sweep();
      set_hint($urandom, $urandom, $urandom);
      test_random(60);
      set_hint(32'd0, 32'sd65536, 32'd0);
      test_random(80);
      drain_results();
      if (failures == 0) begin
         $display("tb_look_at_matrix_builder_unit: PASS");
      end else begin
         $display("tb_look_at_matrix_builder_unit: FAIL");
      end
      $finish;
   end
endmodule

>>> sim.f
sv/lamb_pkg.sv
sv/look_at_matrix_builder_unit.sv
tb/tb_look_at_matrix_builder_unit.sv
